// ===== hdl/ssc_pkg.sv =====
`default_nettype none

package ssc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 20;
    localparam int GUARD         = 8;
    localparam int SQRT_STEPS    = 22;

    localparam int IN_W       = 232;
    localparam int OUT_W      = 96;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT = 2'd2;

    localparam logic [20:0] GAIN_RST        = 21'd32768;
    localparam logic [20:0] MIN_SPEED_RST   = 21'd19661;
    localparam logic [17:0] STEER_LIMIT_RST = 18'd144179;

    // Widths of the CORDIC and square-root datapaths
    localparam int RW     = 44;
    localparam int ZW     = 36;
    localparam int VW     = 56;
    localparam int SQ_W   = 44;
    localparam int REM_W  = 24;
    localparam int ROOT_W = 22;

    localparam logic signed [19:0] PI_F     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_F = 20'sd411774;

    localparam logic signed [ZW-1:0] PI_Q32      = 36'sd13493037705;
    localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sd6746518852;
    localparam logic signed [24:0]   KINV_Q24    = 25'sd10188012;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:10] = '{
        36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
        36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
        36'sd16777131,   36'sd8388597,    36'sd4194303
    };

    typedef struct packed {
        logic [20:0] gain;
        logic [20:0] min_speed;
        logic [17:0] steer_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [18:0]     he;
        logic signed [RW-1:0]   x;
        logic signed [RW-1:0]   y;
        logic signed [ZW-1:0]   z;
        logic [SQ_W-1:0]        sq;
        logic [REM_W-1:0]       rem;
        logic [ROOT_W-1:0]      root;
    } front_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic signed [18:0]   he;
        logic signed [31:0]   ct;
        logic [20:0]          sp;
    } vec_t;

    typedef struct packed {
        logic signed [18:0] steer;
        logic signed [18:0] he;
        logic signed [31:0] ct;
        logic [20:0]        sp;
    } result_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        if (i < 11) begin
            return ATAN_TAB[i];
        end
        return ZW'(36'sd1 <<< (32 - i));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ssc_prep.sv =====
`default_nettype none

module ssc_prep (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire [ssc_pkg::IN_W-1:0]   in_data,
    output logic                      out_valid,
    output ssc_pkg::front_t           out_item
);

    logic signed [31:0] rx, ry, gx, gy;
    logic signed [18:0] ryaw, gyaw;
    logic signed [21:0] vx, vy, vz;

    assign rx   = in_data[31:0];
    assign ry   = in_data[63:32];
    assign ryaw = in_data[82:64];
    assign gx   = in_data[114:83];
    assign gy   = in_data[146:115];
    assign gyaw = in_data[165:147];
    assign vx   = in_data[187:166];
    assign vy   = in_data[209:188];
    assign vz   = in_data[231:210];

    logic               v1_reg;
    logic signed [18:0] he1_reg, he1_next;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [18:0] gyaw1_reg;
    logic [43:0]        sqx1_reg, sqy1_reg, sqz1_reg;

    logic signed [19:0] hd;
    logic signed [43:0] px, py, pz;

    always_comb begin
        hd = 20'(ryaw) - 20'(gyaw);
        if (hd > ssc_pkg::PI_F) begin
            hd = hd - ssc_pkg::TWO_PI_F;
        end else if (hd < -ssc_pkg::PI_F) begin
            hd = hd + ssc_pkg::TWO_PI_F;
        end
        he1_next = hd[18:0];
        px = 44'(vx) * 44'(vx);
        py = 44'(vy) * 44'(vy);
        pz = 44'(vz) * 44'(vz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            he1_reg   <= he1_next;
            dx1_reg   <= 33'(rx) - 33'(gx);
            dy1_reg   <= 33'(ry) - 33'(gy);
            gyaw1_reg <= gyaw;
            sqx1_reg  <= px;
            sqy1_reg  <= py;
            sqz1_reg  <= pz;
        end
    end

    // Second stage: scale the offset by the inverse CORDIC gain, fold the angle, sum the squares
    logic signed [57:0]           mx, my;
    logic signed [ssc_pkg::RW-1:0] x0, y0;
    logic signed [ssc_pkg::ZW-1:0] z0;
    ssc_pkg::front_t              f_next;
    ssc_pkg::front_t              f_reg;
    logic                         v2_reg;

    always_comb begin
        mx = 58'(dx1_reg) * 58'(ssc_pkg::KINV_Q24);
        my = 58'(dy1_reg) * 58'(ssc_pkg::KINV_Q24);
        x0 = ssc_pkg::RW'(mx >>> (24 - ssc_pkg::GUARD));
        y0 = ssc_pkg::RW'(my >>> (24 - ssc_pkg::GUARD));
        z0 = (-ssc_pkg::ZW'(gyaw1_reg)) <<< (32 - ssc_pkg::FRAC_BITS);
        f_next.he   = he1_reg;
        f_next.x    = x0;
        f_next.y    = y0;
        f_next.z    = z0;
        f_next.sq   = sqx1_reg + sqy1_reg + sqz1_reg;
        f_next.rem  = '0;
        f_next.root = '0;
        if (z0 > ssc_pkg::HALF_PI_Q32) begin
            f_next.z = z0 - ssc_pkg::PI_Q32;
            f_next.x = -x0;
            f_next.y = -y0;
        end else if (z0 < -ssc_pkg::HALF_PI_Q32) begin
            f_next.z = z0 + ssc_pkg::PI_Q32;
            f_next.x = -x0;
            f_next.y = -y0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = f_reg;

endmodule

`default_nettype wire

// ===== hdl/ssc_rot_sqrt.sv =====
`default_nettype none

// Rotation CORDIC and digit-by-digit square root side by side, one step per stage
module ssc_rot_sqrt #(
    parameter int CORDIC_STAGES = ssc_pkg::CORDIC_STAGES
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             en,
    input  wire             in_valid,
    input  ssc_pkg::front_t in_item,
    output logic            out_valid,
    output ssc_pkg::front_t out_item
);

    localparam int L = (CORDIC_STAGES > ssc_pkg::SQRT_STEPS) ?
                       CORDIC_STAGES : ssc_pkg::SQRT_STEPS;

    ssc_pkg::front_t st_reg [0:L-1];
    logic [L-1:0]    vld_reg;

    for (genvar i = 0; i < L; i++) begin : g_stage
        ssc_pkg::front_t               cur;
        ssc_pkg::front_t               st_next;
        logic                          cur_v;
        logic signed [ssc_pkg::RW-1:0] xs, ys;
        logic [ssc_pkg::REM_W+1:0]     remw, trial;

        if (i == 0) begin : g_first
            assign cur   = in_item;
            assign cur_v = in_valid;
        end else begin : g_rest
            assign cur   = st_reg[i-1];
            assign cur_v = vld_reg[i-1];
        end

        always_comb begin
            st_next = cur;
            xs      = $signed(cur.x) >>> i;
            ys      = $signed(cur.y) >>> i;
            remw    = {cur.rem, cur.sq[ssc_pkg::SQ_W-1 -: 2]};
            trial   = (ssc_pkg::REM_W+2)'({cur.root, 2'b01});
            if (i < CORDIC_STAGES) begin
                if (cur.z >= 0) begin
                    st_next.x = cur.x - ys;
                    st_next.y = cur.y + xs;
                    st_next.z = cur.z - ssc_pkg::atan_entry(i);
                end else begin
                    st_next.x = cur.x + ys;
                    st_next.y = cur.y - xs;
                    st_next.z = cur.z + ssc_pkg::atan_entry(i);
                end
            end
            if (i < ssc_pkg::SQRT_STEPS) begin
                st_next.sq = cur.sq << 2;
                if (remw >= trial) begin
                    st_next.rem  = ssc_pkg::REM_W'(remw - trial);
                    st_next.root = {cur.root[ssc_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    st_next.rem  = ssc_pkg::REM_W'(remw);
                    st_next.root = {cur.root[ssc_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next;
            end
        end
    end

    assign out_valid = vld_reg[L-1];
    assign out_item  = st_reg[L-1];

endmodule

`default_nettype wire

// ===== hdl/ssc_vec.sv =====
`default_nettype none

// Cross-track rounding, gain multiply, vectoring CORDIC and steering clamp
module ssc_vec #(
    parameter int CORDIC_STAGES = ssc_pkg::CORDIC_STAGES
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              en,
    input  ssc_pkg::cfg_t    cfg,
    input  wire              in_valid,
    input  ssc_pkg::front_t  in_item,
    output logic             out_valid,
    output ssc_pkg::result_t out_item
);

    // Round and saturate the cross-track error, saturate the speed
    logic signed [ssc_pkg::RW-1:0] yr;
    logic signed [31:0]            ct_next;
    logic [20:0]                   sp_next;
    logic                          r1_v_reg;
    logic signed [18:0]            r1_he_reg;
    logic signed [31:0]            r1_ct_reg;
    logic [20:0]                   r1_sp_reg;

    always_comb begin
        yr = ($signed(in_item.y) + ssc_pkg::RW'(1 << (ssc_pkg::GUARD - 1)))
             >>> ssc_pkg::GUARD;
        if (yr > ssc_pkg::RW'(64'sh7fffffff)) begin
            ct_next = 32'sh7fffffff;
        end else if (yr < -ssc_pkg::RW'(64'sh80000000)) begin
            ct_next = 32'sh80000000;
        end else begin
            ct_next = yr[31:0];
        end
        if (in_item.root[ssc_pkg::ROOT_W-1]) begin
            sp_next = '1;
        end else begin
            sp_next = in_item.root[20:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_v_reg <= 1'b0;
        end else if (en) begin
            r1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_he_reg <= in_item.he;
            r1_ct_reg <= ct_next;
            r1_sp_reg <= sp_next;
        end
    end

    // Numerator and floored denominator of the atan2 term
    logic signed [53:0] num;
    logic [20:0]        spd;
    ssc_pkg::vec_t      v0_next;
    ssc_pkg::vec_t      v0_reg;
    logic               v0_v_reg;

    always_comb begin
        num = 54'($signed({1'b0, cfg.gain})) * 54'(r1_ct_reg);
        spd = (r1_sp_reg > cfg.min_speed) ? r1_sp_reg : cfg.min_speed;
        v0_next.x    = ssc_pkg::VW'({spd, {ssc_pkg::FRAC_BITS{1'b0}}});
        v0_next.y    = ssc_pkg::VW'(num);
        v0_next.z    = '0;
        v0_next.zero = (num == '0);
        v0_next.he   = r1_he_reg;
        v0_next.ct   = r1_ct_reg;
        v0_next.sp   = r1_sp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_v_reg <= 1'b0;
        end else if (en) begin
            v0_v_reg <= r1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v0_reg <= v0_next;
        end
    end

    ssc_pkg::vec_t            st_reg [0:CORDIC_STAGES-1];
    logic [CORDIC_STAGES-1:0] vld_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        ssc_pkg::vec_t                 cur;
        ssc_pkg::vec_t                 st_next;
        logic                          cur_v;
        logic signed [ssc_pkg::VW-1:0] xs, ys;

        if (i == 0) begin : g_first
            assign cur   = v0_reg;
            assign cur_v = v0_v_reg;
        end else begin : g_rest
            assign cur   = st_reg[i-1];
            assign cur_v = vld_reg[i-1];
        end

        always_comb begin
            st_next = cur;
            xs      = $signed(cur.x) >>> i;
            ys      = $signed(cur.y) >>> i;
            if (cur.y > 0) begin
                st_next.x = cur.x + ys;
                st_next.y = cur.y - xs;
                st_next.z = cur.z + ssc_pkg::atan_entry(i);
            end else begin
                st_next.x = cur.x - ys;
                st_next.y = cur.y + xs;
                st_next.z = cur.z - ssc_pkg::atan_entry(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next;
            end
        end
    end

    // Round the angle, add the heading error, clamp
    ssc_pkg::vec_t                 last;
    logic signed [ssc_pkg::ZW-1:0] zr;
    logic signed [19:0]            ang;
    logic signed [20:0]            steer, lim;
    ssc_pkg::result_t              res_next;
    ssc_pkg::result_t              res_reg;
    logic                          res_v_reg;

    assign last = st_reg[CORDIC_STAGES-1];

    always_comb begin
        zr = (last.z + ssc_pkg::ZW'(1 << (31 - ssc_pkg::FRAC_BITS)))
             >>> (32 - ssc_pkg::FRAC_BITS);
        ang   = last.zero ? 20'sd0 : zr[19:0];
        steer = -(21'(last.he) + 21'(ang));
        lim   = 21'($signed({1'b0, cfg.steer_limit}));
        if (steer > lim) begin
            steer = lim;
        end
        if (steer < -lim) begin
            steer = -lim;
        end
        res_next.steer = steer[18:0];
        res_next.he    = last.he;
        res_next.ct    = last.ct;
        res_next.sp    = last.sp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_v_reg <= 1'b0;
        end else if (en) begin
            res_v_reg <= vld_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_v_reg;
    assign out_item  = res_reg;

endmodule

`default_nettype wire

// ===== hdl/stanley_steering_controller.sv =====
// Channel   | Direction | Content
// s_axis    | in        | pose, goal pose and velocity, one transaction per sample
// m_axis    | out       | steer_rate, heading_err, cross_track, speed
// cfg       | in        | register write: cfg_index selects gain, min speed, limit
//
// Samples pass through the prep registers, the rotation CORDIC / 22-step square root,
// the rounding and numerator registers, the vectoring CORDIC and the clamp register.
// One transaction is taken per cycle whenever the output register is free or drained.
// A stall on m_axis holds every stage in place; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and reloads the registers.
`default_nettype none

module stanley_steering_controller #(
    parameter int CORDIC_STAGES = ssc_pkg::CORDIC_STAGES
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // robot_x, robot_y, robot_yaw, goal_x, goal_y, goal_yaw, vel_x, vel_y, vel_z
    input  wire [ssc_pkg::IN_W-1:0]         s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // steer_rate, heading_err, cross_track, speed, zero fill
    output logic [ssc_pkg::OUT_W-1:0]       m_tdata,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [ssc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ssc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain        <= ssc_pkg::GAIN_RST;
            cfg_reg.min_speed   <= ssc_pkg::MIN_SPEED_RST;
            cfg_reg.steer_limit <= ssc_pkg::STEER_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ssc_pkg::REG_GAIN:        cfg_reg.gain        <= cfg_data[20:0];
                ssc_pkg::REG_MIN_SPEED:   cfg_reg.min_speed   <= cfg_data[20:0];
                ssc_pkg::REG_STEER_LIMIT: cfg_reg.steer_limit <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output holds an untaken result
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic             prep_v, front_v;
    ssc_pkg::front_t  prep_item, front_item;
    ssc_pkg::result_t res;

    ssc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (prep_v),
        .out_item  (prep_item)
    );

    ssc_rot_sqrt #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_rot_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_v),
        .in_item   (prep_item),
        .out_valid (front_v),
        .out_item  (front_item)
    );

    ssc_vec #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (front_v),
        .in_item   (front_item),
        .out_valid (m_tvalid),
        .out_item  (res)
    );

    assign m_tdata = {5'b0, res.sp, res.ct, res.he, res.steer};

endmodule

`default_nettype wire

// ===== hdl/ssc_checker.sv =====
`default_nettype none

module ssc_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [ssc_pkg::IN_W-1:0]         s_tdata,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [ssc_pkg::OUT_W-1:0]        m_tdata,
    input wire                             cfg_valid,
    input wire                             cfg_ready,
    input wire [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire [ssc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    a_accept_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input refused with empty output register");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[37:19]) <= 19'(ssc_pkg::PI_F)) &&
                     ($signed(m_tdata[37:19]) >= -19'(ssc_pkg::PI_F)))
        else $error("heading error outside wrap range");

endmodule

bind stanley_steering_controller ssc_checker u_ssc_checker (.*);

`default_nettype wire
